// ===== src/irc_ltv_pkg.sv =====
package irc_ltv_pkg;

   // Parser phases within one line.
   localparam logic [3:0] PH_START      = 4'd0;
   localparam logic [3:0] PH_NICK       = 4'd1;
   localparam logic [3:0] PH_USER       = 4'd2;
   localparam logic [3:0] PH_HOST       = 4'd3;
   localparam logic [3:0] PH_CMD_SKIP   = 4'd4;
   localparam logic [3:0] PH_CMD        = 4'd5;
   localparam logic [3:0] PH_PARAM_SKIP = 4'd6;
   localparam logic [3:0] PH_MIDDLE     = 4'd7;
   localparam logic [3:0] PH_TRAIL      = 4'd8;

   // Command kinds seen so far.
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_ALPHA = 2'd1;
   localparam logic [1:0] KIND_DIGIT = 2'd2;
   localparam logic [1:0] KIND_BAD   = 2'd3;

   // Byte classes.
   localparam logic [2:0] CLS_DROPPED   = 3'd0;
   localparam logic [2:0] CLS_PREFIX    = 3'd1;
   localparam logic [2:0] CLS_COMMAND   = 3'd2;
   localparam logic [2:0] CLS_MIDDLE    = 3'd3;
   localparam logic [2:0] CLS_TRAILING  = 3'd4;
   localparam logic [2:0] CLS_DELIMITER = 3'd5;
   localparam logic [2:0] CLS_AFTER_ERR = 3'd6;

   // Error codes.
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_PREFIX_ONLY = 3'd1;
   localparam logic [2:0] ERR_BAD_NICK    = 3'd2;
   localparam logic [2:0] ERR_BAD_USER    = 3'd3;
   localparam logic [2:0] ERR_EMPTY_HOST  = 3'd4;
   localparam logic [2:0] ERR_BAD_COMMAND = 3'd5;
   localparam logic [2:0] ERR_BAD_PARAM   = 3'd6;

   // Characters of interest.
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   localparam logic [3:0] FIELD_LEN_MAX   = 4'd15;
   localparam logic [3:0] NUMERIC_CMD_LEN = 4'd3;

   // Per-line parser state, apart from the parameter counter.
   typedef struct packed {
      logic [3:0] phase;
      logic [3:0] field_length;
      logic [1:0] command_kind;
      logic [2:0] error_held;
      logic       nick_bad;
      logic       user_bad;
      logic       seen_bang;
   } parse_state_type;

   localparam parse_state_type PARSE_STATE_CLEAR = '{
      phase: PH_START, field_length: 4'd0, command_kind: KIND_NONE,
      error_held: ERR_NONE, nick_bad: 1'b0, user_bad: 1'b0, seen_bang: 1'b0};

   // One result beat.
   typedef struct packed {
      logic [2:0] byte_class;
      logic [3:0] param_index;
      logic       line_done;
      logic       line_valid;
      logic [2:0] error_code;
   } result_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_special(input logic [7:0] c);
      return (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7D);
   endfunction

   function automatic logic [1:0] kind_of(input logic [7:0] c);
      return is_letter(c) ? KIND_ALPHA : (is_digit(c) ? KIND_DIGIT : KIND_BAD);
   endfunction

   function automatic logic command_ok(input logic [1:0] kind, input logic [3:0] len);
      return (kind == KIND_ALPHA) || (kind == KIND_DIGIT && len == NUMERIC_CMD_LEN);
   endfunction

   function automatic logic [3:0] len_inc(input logic [3:0] len);
      return (len != FIELD_LEN_MAX) ? len + 4'd1 : len;
   endfunction

endpackage

// ===== src/irc_ltv_parser.sv =====
module irc_ltv_parser #(
   parameter int MAX_PARAM_INDEX = 15,
   parameter int PW = $clog2(MAX_PARAM_INDEX + 1)
) (
   input  irc_ltv_pkg::parse_state_type state,
   input  logic [PW-1:0]                param_count,
   input  logic [3:0]                   max_nick_length,
   input  logic [7:0]                   data_byte,
   input  logic                         last_byte,
   output irc_ltv_pkg::parse_state_type state_next,
   output logic [PW-1:0]                param_count_next,
   output irc_ltv_pkg::result_type      result
);
   import irc_ltv_pkg::*;

   localparam logic [PW-1:0] PARAM_LIMIT = PW'(MAX_PARAM_INDEX);

   parse_state_type s;
   logic [PW-1:0]   cnt;
   logic [2:0]      cls;
   logic            show_idx;
   logic            nick_ok;
   logic [PW+3:0]   cnt_ext;

   assign cnt_ext = {4'd0, param_count};

   // Nickname character test; the first character may not be a digit or '-'.
   always_comb begin
      if (state.field_length == 4'd0) begin
         nick_ok = is_letter(data_byte) || is_special(data_byte);
      end else begin
         nick_ok = is_letter(data_byte) || is_digit(data_byte) ||
                   is_special(data_byte) || data_byte == CH_DASH;
      end
   end

   // One byte of the line: classify it and advance the parser.
   always_comb begin
      s        = state;
      cnt      = param_count;
      cls      = CLS_DELIMITER;
      show_idx = 1'b0;

      if (data_byte == CH_CR || data_byte == CH_LF) begin
         cls = CLS_DROPPED;
      end else if (state.error_held != ERR_NONE) begin
         cls = CLS_AFTER_ERR;
      end else begin
         case (state.phase)
            PH_START: begin
               if (data_byte == CH_COLON) begin
                  s.phase        = PH_NICK;
                  s.field_length = 4'd0;
                  cls            = CLS_PREFIX;
               end else if (data_byte == CH_SPACE) begin
                  s.phase = PH_CMD_SKIP;
               end else begin
                  s.command_kind = kind_of(data_byte);
                  s.field_length = 4'd1;
                  s.phase        = PH_CMD;
                  cls            = CLS_COMMAND;
               end
            end
            PH_NICK, PH_USER, PH_HOST: begin
               cls = CLS_PREFIX;
               if (data_byte == CH_SPACE) begin
                  // The prefix is judged at the space that ends it.
                  cls     = CLS_DELIMITER;
                  s.phase = PH_CMD_SKIP;
                  if (state.phase == PH_NICK) begin
                     if (state.field_length == 4'd0 || state.nick_bad) begin
                        s.error_held = ERR_BAD_NICK;
                     end
                  end else if (state.phase == PH_USER) begin
                     s.error_held = ERR_BAD_NICK;
                  end else if (state.field_length == 4'd0) begin
                     s.error_held = ERR_EMPTY_HOST;
                  end else if (state.seen_bang && state.user_bad) begin
                     s.error_held = ERR_BAD_USER;
                  end else if (state.nick_bad) begin
                     s.error_held = ERR_BAD_NICK;
                  end
               end else if (state.phase == PH_NICK &&
                            (data_byte == CH_BANG || data_byte == CH_AT)) begin
                  if (state.field_length == 4'd0) begin
                     s.nick_bad = 1'b1;
                  end
                  if (data_byte == CH_BANG) begin
                     s.seen_bang = 1'b1;
                     s.phase     = PH_USER;
                  end else begin
                     s.phase = PH_HOST;
                  end
                  s.field_length = 4'd0;
               end else if (state.phase == PH_USER && data_byte == CH_AT) begin
                  if (state.field_length == 4'd0) begin
                     s.user_bad = 1'b1;
                  end
                  s.phase        = PH_HOST;
                  s.field_length = 4'd0;
               end else begin
                  if (state.phase == PH_NICK &&
                      (!nick_ok || state.field_length >= max_nick_length)) begin
                     s.nick_bad = 1'b1;
                  end
                  if (state.phase == PH_USER && (data_byte < CH_SPACE || data_byte == CH_DEL)) begin
                     s.user_bad = 1'b1;
                  end
                  s.field_length = len_inc(state.field_length);
               end
            end
            PH_CMD_SKIP: begin
               if (data_byte != CH_SPACE) begin
                  s.command_kind = kind_of(data_byte);
                  s.field_length = 4'd1;
                  s.phase        = PH_CMD;
                  cls            = CLS_COMMAND;
               end
            end
            PH_CMD: begin
               if (data_byte == CH_SPACE) begin
                  if (!command_ok(state.command_kind, state.field_length)) begin
                     s.error_held = ERR_BAD_COMMAND;
                  end
                  s.phase = PH_PARAM_SKIP;
               end else begin
                  if (state.command_kind == KIND_ALPHA && !is_letter(data_byte)) begin
                     s.command_kind = KIND_BAD;
                  end else if (state.command_kind == KIND_DIGIT && !is_digit(data_byte)) begin
                     s.command_kind = KIND_BAD;
                  end
                  s.field_length = len_inc(state.field_length);
                  cls            = CLS_COMMAND;
               end
            end
            PH_PARAM_SKIP: begin
               if (data_byte == CH_COLON) begin
                  s.phase = PH_TRAIL;
                  cls     = CLS_TRAILING;
               end else if (data_byte != CH_SPACE) begin
                  s.phase  = PH_MIDDLE;
                  cls      = CLS_MIDDLE;
                  show_idx = 1'b1;
               end
            end
            PH_MIDDLE: begin
               if (data_byte == CH_SPACE) begin
                  if (param_count < PARAM_LIMIT) begin
                     cnt = param_count + PW'(1);
                  end
                  s.phase = PH_PARAM_SKIP;
               end else begin
                  if (data_byte == CH_COLON) begin
                     s.error_held = ERR_BAD_PARAM;
                  end
                  cls      = CLS_MIDDLE;
                  show_idx = 1'b1;
               end
            end
            default: begin
               cls = CLS_TRAILING;
            end
         endcase
      end

      // End of line: judge whatever is still open.
      if (last_byte && s.error_held == ERR_NONE) begin
         if (s.phase == PH_NICK || s.phase == PH_USER || s.phase == PH_HOST) begin
            s.error_held = ERR_PREFIX_ONLY;
         end else if (s.phase == PH_START || s.phase == PH_CMD_SKIP) begin
            s.error_held = ERR_BAD_COMMAND;
         end else if (s.phase == PH_CMD && !command_ok(s.command_kind, s.field_length)) begin
            s.error_held = ERR_BAD_COMMAND;
         end
      end
   end

   // Result beat and the state carried into the next byte.
   always_comb begin
      result.byte_class  = cls;
      result.param_index = show_idx ? cnt_ext[3:0] : 4'd0;
      result.line_done   = last_byte;
      result.line_valid  = last_byte && (s.error_held == ERR_NONE);
      result.error_code  = s.error_held;
      if (last_byte) begin
         state_next       = PARSE_STATE_CLEAR;
         param_count_next = '0;
      end else begin
         state_next       = s;
         param_count_next = cnt;
      end
   end

endmodule

// ===== src/irc_line_tokenizer_validator.sv =====
// IRC line tokenizer and validator. Bytes of a line enter one per beat on the req_ stream,
// with req_tlast on the final byte, and each byte gives exactly one result beat on the rsp_
// stream in the cycle after it is taken: its class, the middle-parameter index, and on the last
// byte the line verdict with the first error found. CR and LF are dropped anywhere. A new byte
// is taken in every cycle in which rsp_tready is high; the combinational parser next-state logic
// sets this rate. While a result waits for rsp_tready no new byte is taken, and a byte can
// enter in the same cycle that the waiting result leaves. The user must write the nickname
// limit through csr_we/csr_wdata only while the block is idle; the block does not enforce it.
module irc_line_tokenizer_validator #(
   parameter int MAX_PARAM_INDEX = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata,   // max_nick_length
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // byte_class[2:0], param_index[6:3],
                                    // line_valid[7], error_code[10:8], zeros above
   output logic        rsp_tlast    // line_done
);
   import irc_ltv_pkg::*;

   localparam int PW = $clog2(MAX_PARAM_INDEX + 1);
   localparam logic [3:0] NICK_LEN_RESET = 4'd9;

   logic            accept;
   logic [3:0]      max_nick_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   logic [PW-1:0]   count_ff;
   logic [PW-1:0]   count_in;
   result_type      result_in;
   result_type      result_ff;
   logic            rsp_valid_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   irc_ltv_parser #(
      .MAX_PARAM_INDEX(MAX_PARAM_INDEX),
      .PW(PW)
   ) u_parser (
      .state           (state_ff),
      .param_count     (count_ff),
      .max_nick_length (max_nick_ff),
      .data_byte       (req_tdata),
      .last_byte       (req_tlast),
      .state_next      (state_in),
      .param_count_next(count_in),
      .result          (result_in)
   );

   // Nickname length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_nick_ff <= NICK_LEN_RESET;
      end else if (csr_we) begin
         max_nick_ff <= csr_wdata;
      end
   end

   // Parser state advances on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_STATE_CLEAR;
         count_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Result register and its valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = result_ff.line_done;
   assign rsp_tdata  = {5'd0, result_ff.error_code, result_ff.line_valid,
                        result_ff.param_index, result_ff.byte_class};

   // A valid line carries no error code and only ever appears on the last beat.
   a_valid_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.line_valid |->
         result_ff.line_done && result_ff.error_code == ERR_NONE)
      else $error("valid line reported with an error or before the last byte");

   // A parameter index shows only on middle parameter bytes.
   a_index_middle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.param_index != 4'd0 |->
         result_ff.byte_class == CLS_MIDDLE)
      else $error("parameter index on a byte that is not a middle parameter");

   // After the last byte of a line the parser is back at the start.
   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=>
         state_ff.phase == PH_START && state_ff.error_held == ERR_NONE && count_ff == '0)
      else $error("parser state not cleared after the end of a line");

   // Once an error is held, further non-CR/LF bytes of the line are marked after-error.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      accept && state_ff.error_held != ERR_NONE && req_tdata != CH_CR && req_tdata != CH_LF |=>
         result_ff.byte_class == CLS_AFTER_ERR && result_ff.error_code != ERR_NONE)
      else $error("byte after an error not marked as such");

   // A waiting result holds while the consumer stalls.
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(result_ff))
      else $error("stalled result changed");

endmodule
